/* rtl/u2w_pkg.sv */
// shared types and constants for the utf-8 to wide code unit decoder
// used by every module of the decoder; depends on nothing
package u2w_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_REPL       = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_HI_BASE    = 21'h00D800;
    localparam logic [CP_W-1:0] CP_LO_BASE    = 21'h00DC00;
    localparam logic [CP_W-1:0] CP_SUPP_BASE  = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_MIN_LEN2   = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_LEN3   = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_LEN4   = 21'h010000;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    localparam logic [1:0] CFG_ADDR_MODE = 2'd0;

    // one decoded item: replacements for held bytes, then an optional code point
    typedef struct packed {
        logic [1:0]      rep_cnt;
        logic            has_tail;
        logic            pair;
        logic [CP_W-1:0] cp;
    } t_desc;

endpackage

/* rtl/utf8_to_wide_decoder_core.sv */
// utf-8 to wide code unit decoder, top level with apb mode register
// path: the first unit of an accepted byte is registered in the descriptor queue, then in the output register
// throughput: one byte per cycle while each item yields one unit and the result side is popped;
// an item with n units holds the unit sequencer until all are issued, the descriptor queue absorbs the difference
// reset: synchronous active low, clears sequence state, queue, output and mode (1-bit)
module utf8_to_wide_decoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_byte_value,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] o_code_unit,
    output logic        o_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                            r_mode;
    logic                            accept;
    logic                            f_push;
    u2w_pkg::t_desc                  f_desc;
    logic                            q_valid;
    u2w_pkg::t_desc                  q_desc;
    logic                            q_pop;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    assign pready = 1'b1;
    assign prdata = (paddr == u2w_pkg::CFG_ADDR_MODE) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr == u2w_pkg::CFG_ADDR_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    assign accept = push && !full;

    u2w_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_op),
        .i_byte   (i_byte_value),
        .i_mode   (r_mode),
        .o_push   (f_push),
        .o_desc   (f_desc)
    );

    u2w_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_desc  (f_desc),
        .o_full  (full),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .i_pop   (q_pop),
        .o_count (q_count)
    );

    u2w_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_desc      (q_desc),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_code_unit (o_code_unit),
        .o_last      (o_last_of_run)
    );

`ifndef SYNTHESIS
    // queue occupancy never passes its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("descriptor queue overflow");

    // every queued descriptor yields at least one unit
    a_desc_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (q_desc.rep_cnt != 2'd0 || q_desc.has_tail))
        else $error("queued descriptor produces no unit");

    // no unit above the unicode range ever reaches the result side
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_code_unit <= u2w_pkg::CP_MAX)
        else $error("code unit out of range");

    // reset leaves nothing on the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");
`endif

endmodule

/* rtl/u2w_front.sv */
// front end: sequence state, byte classification and code point assembly
// produces one descriptor per item that yields results; depends on u2w_pkg
module u2w_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_op,
    input  logic [7:0]         i_byte,
    input  logic               i_mode,
    output logic               o_push,
    output u2w_pkg::t_desc     o_desc
);

    logic [2:0]                r_exp;
    logic [2:0]                r_held;
    logic [u2w_pkg::CP_W-1:0]  r_part;
    logic [2:0]                n_exp;
    logic [2:0]                n_held;
    logic [u2w_pkg::CP_W-1:0]  n_part;

    logic [u2w_pkg::CP_W-1:0]  acc;
    logic [2:0]                held_inc;
    logic [u2w_pkg::CP_W-1:0]  min_cp;
    logic                      do_lead;
    logic [1:0]                rep_cnt;
    logic                      has_tail;
    logic [u2w_pkg::CP_W-1:0]  tail_cp;

    assign acc      = {r_part[u2w_pkg::CP_W-7:0], i_byte[5:0]};
    assign held_inc = r_held + 3'd1;

    always_comb begin
        unique case (r_exp)
            u2w_pkg::SEQ_LEN2: min_cp = u2w_pkg::CP_MIN_LEN2;
            u2w_pkg::SEQ_LEN3: min_cp = u2w_pkg::CP_MIN_LEN3;
            default:           min_cp = u2w_pkg::CP_MIN_LEN4;
        endcase
    end

    always_comb begin
        n_exp    = r_exp;
        n_held   = r_held;
        n_part   = r_part;
        rep_cnt  = 2'd0;
        has_tail = 1'b0;
        tail_cp  = u2w_pkg::CP_REPL;
        do_lead  = 1'b0;
        if (i_op == u2w_pkg::OP_EOS) begin
            rep_cnt = r_held[1:0];
            n_exp   = u2w_pkg::SEQ_NONE;
            n_held  = 3'd0;
            n_part  = '0;
        end else if (r_exp != u2w_pkg::SEQ_NONE) begin
            if (i_byte[7:6] == 2'b10) begin
                if (held_inc >= r_exp) begin
                    has_tail = 1'b1;
                    // overlong, out of range or surrogate gives one replacement
                    if (acc < min_cp || acc > u2w_pkg::CP_MAX ||
                        (acc >= u2w_pkg::CP_SURR_LO && acc <= u2w_pkg::CP_SURR_HI)) begin
                        tail_cp = u2w_pkg::CP_REPL;
                    end else begin
                        tail_cp = acc;
                    end
                    n_exp  = u2w_pkg::SEQ_NONE;
                    n_held = 3'd0;
                    n_part = '0;
                end else begin
                    n_part = acc;
                    n_held = held_inc;
                end
            end else begin
                // broken sequence: flush held bytes, then decode this byte as a lead
                rep_cnt = r_held[1:0];
                n_exp   = u2w_pkg::SEQ_NONE;
                n_held  = 3'd0;
                n_part  = '0;
                do_lead = 1'b1;
            end
        end else begin
            do_lead = 1'b1;
        end

        if (do_lead) begin
            priority if (i_byte[7] == 1'b0) begin
                has_tail = 1'b1;
                tail_cp  = {13'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_exp  = u2w_pkg::SEQ_LEN2;
                n_held = 3'd1;
                n_part = {16'd0, i_byte[4:0]};
            end else if (i_byte[7:4] == 4'b1110) begin
                n_exp  = u2w_pkg::SEQ_LEN3;
                n_held = 3'd1;
                n_part = {17'd0, i_byte[3:0]};
            end else if (i_byte[7:3] == 5'b11110) begin
                n_exp  = u2w_pkg::SEQ_LEN4;
                n_held = 3'd1;
                n_part = {18'd0, i_byte[2:0]};
            end else begin
                has_tail = 1'b1;
                tail_cp  = u2w_pkg::CP_REPL;
            end
        end
    end

    assign o_push          = i_accept && (rep_cnt != 2'd0 || has_tail);
    assign o_desc.rep_cnt  = rep_cnt;
    assign o_desc.has_tail = has_tail;
    assign o_desc.pair     = i_mode && has_tail && (tail_cp >= u2w_pkg::CP_SUPP_BASE);
    assign o_desc.cp       = tail_cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= u2w_pkg::SEQ_NONE;
            r_held <= 3'd0;
            r_part <= '0;
        end else if (i_accept) begin
            r_exp  <= n_exp;
            r_held <= n_held;
            r_part <= n_part;
        end
    end

endmodule

/* rtl/u2w_queue.sv */
// short descriptor queue between the front end and the unit sequencer
// register based, first in first out; depends on u2w_pkg
module u2w_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u2w_pkg::t_desc     i_desc,
    output logic               o_full,
    output logic               o_valid,
    output u2w_pkg::t_desc     o_desc,
    input  logic               i_pop,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u2w_pkg::t_desc    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/u2w_back.sv */
// back end: expands a descriptor into code units, one per cycle while the output register is empty or being popped
// splits supplementary code points into surrogate pairs when the descriptor marks a pair; depends on u2w_pkg
module u2w_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  u2w_pkg::t_desc             i_desc,
    output logic                       o_q_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [u2w_pkg::CP_W-1:0]   o_code_unit,
    output logic                       o_last
);

    logic [2:0]                r_idx;
    logic                      r_out_valid;
    logic [u2w_pkg::CP_W-1:0]  r_out_unit;
    logic                      r_out_last;

    logic [2:0]                total;
    logic [2:0]                rep3;
    logic [u2w_pkg::CP_W-1:0]  supp_off;
    logic [u2w_pkg::CP_W-1:0]  hi_unit;
    logic [u2w_pkg::CP_W-1:0]  lo_unit;
    logic [u2w_pkg::CP_W-1:0]  n_unit;
    logic                      n_last;
    logic                      advance;

    assign rep3     = {1'b0, i_desc.rep_cnt};
    assign total    = rep3 + (i_desc.has_tail ? (i_desc.pair ? 3'd2 : 3'd1) : 3'd0);
    assign supp_off = i_desc.cp - u2w_pkg::CP_SUPP_BASE;
    assign hi_unit  = u2w_pkg::CP_HI_BASE + {11'd0, supp_off[19:10]};
    assign lo_unit  = u2w_pkg::CP_LO_BASE + {11'd0, supp_off[9:0]};

    always_comb begin
        if (r_idx < rep3) begin
            n_unit = u2w_pkg::CP_REPL;
        end else if (i_desc.pair) begin
            n_unit = (r_idx == rep3) ? hi_unit : lo_unit;
        end else begin
            n_unit = i_desc.cp;
        end
    end

    assign n_last  = (r_idx == total - 3'd1);
    // output register can take a unit when empty or being drained this cycle
    assign advance = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop = advance && n_last;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_unit <= n_unit;
            r_out_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx       <= n_last ? 3'd0 : r_idx + 3'd1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_code_unit = r_out_unit;
    assign o_last      = r_out_last;

endmodule

/* tb/sv/utf8_to_wide_decoder_core_test.sv */
// self-checking testbench for utf8_to_wide_decoder_core: queue-style byte and unit handshakes
// with random idling, apb mode writes between phases, and an in-bench utf-8 decoder predictor
// depends on u2w_pkg and the decoder rtl
module utf8_to_wide_decoder_core_test;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
    } t_text_item;

    typedef struct packed {
        logic [u2w_pkg::CP_W-1:0] code_unit;
        logic                     last_of_run;
    } t_wide_unit;

    localparam int IDLE_LIMIT   = 500;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIRECTED_N   = 26;
    // 9-bit entries, bit 8 set marks an end of string item
    localparam logic [DIRECTED_N*9-1:0] DIRECTED = {
        9'h000, 9'h07F,                         // ascii extremes
        9'h0C2, 9'h080,                         // smallest two-byte point
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,         // largest code point
        9'h0ED, 9'h0A0, 9'h080,                 // encoded surrogate
        9'h0C0, 9'h080,                         // overlong two-byte
        9'h0F5, 9'h080, 9'h080, 9'h080,         // lead above the code space
        9'h0FF, 9'h080,                         // bad leads
        9'h0E2, 9'h082, 9'h041,                 // sequence cut by ascii
        9'h0F0, 9'h090, 9'h100,                 // end of string with bytes held
        9'h100                                  // end of string with nothing held
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic        i_op         = u2w_pkg::OP_DATA;
    logic [7:0]  i_byte_value = 8'd0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [20:0] o_code_unit;
    logic        o_last_of_run;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [1:0]  paddr        = u2w_pkg::CFG_ADDR_MODE;
    logic [31:0] pwdata       = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    utf8_to_wide_decoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_byte_value  (i_byte_value),
        .empty         (empty),
        .pop           (pop),
        .o_code_unit   (o_code_unit),
        .o_last_of_run (o_last_of_run),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state, mirrors the decoder
    logic                     mode16   = 1'b0;
    logic [2:0]               seq_len  = u2w_pkg::SEQ_NONE;
    logic [2:0]               seq_held = 3'd0;
    logic [u2w_pkg::CP_W-1:0] seq_cp   = '0;
    logic [u2w_pkg::CP_W-1:0] item_units[$];
    t_wide_unit               expected_units[$];

    t_text_item  text_items[$];
    t_text_item  next_item;
    int unsigned gap_max   = 3;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned pop_hold;
    int unsigned idle_cycles = 0;
    int          errors      = 0;
    int          items_taken = 0;
    int          units_checked = 0;
    int          repl_seen   = 0;
    int          halves_seen = 0;
    t_wide_unit  want;

    function automatic void emit_point(input logic [u2w_pkg::CP_W-1:0] cp);
        logic [u2w_pkg::CP_W-1:0] v;
        if (mode16 && cp >= u2w_pkg::CP_SUPP_BASE) begin
            v = cp - u2w_pkg::CP_SUPP_BASE;
            item_units = {item_units, u2w_pkg::CP_HI_BASE + {11'd0, v[19:10]}};
            item_units = {item_units, u2w_pkg::CP_LO_BASE + {11'd0, v[9:0]}};
        end else begin
            item_units = {item_units, cp};
        end
    endfunction

    function automatic void clear_seq();
        seq_len  = u2w_pkg::SEQ_NONE;
        seq_held = 3'd0;
        seq_cp   = '0;
    endfunction

    function automatic void flush_held();
        repeat (seq_held) emit_point(u2w_pkg::CP_REPL);
        clear_seq();
    endfunction

    function automatic void finish_seq();
        logic [u2w_pkg::CP_W-1:0] floor_cp;
        logic [u2w_pkg::CP_W-1:0] cp;
        floor_cp = (seq_len == u2w_pkg::SEQ_LEN2) ? u2w_pkg::CP_MIN_LEN2 :
                   (seq_len == u2w_pkg::SEQ_LEN3) ? u2w_pkg::CP_MIN_LEN3 :
                                                    u2w_pkg::CP_MIN_LEN4;
        cp = seq_cp;
        if (cp < floor_cp || cp > u2w_pkg::CP_MAX ||
            (cp >= u2w_pkg::CP_SURR_LO && cp <= u2w_pkg::CP_SURR_HI))
            cp = u2w_pkg::CP_REPL;
        emit_point(cp);
        clear_seq();
    endfunction

    function automatic void start_lead(input logic [7:0] b);
        if (b[7] == 1'b0) begin
            emit_point({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
            seq_len  = u2w_pkg::SEQ_LEN2;
            seq_held = 3'd1;
            seq_cp   = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            seq_len  = u2w_pkg::SEQ_LEN3;
            seq_held = 3'd1;
            seq_cp   = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            seq_len  = u2w_pkg::SEQ_LEN4;
            seq_held = 3'd1;
            seq_cp   = {18'd0, b[2:0]};
        end else begin
            emit_point(u2w_pkg::CP_REPL);
        end
    endfunction

    function automatic void decode_item(input logic op, input logic [7:0] b);
        t_wide_unit w;
        item_units.delete();
        if (op == u2w_pkg::OP_EOS) begin
            flush_held();
        end else if (seq_len != u2w_pkg::SEQ_NONE) begin
            if (b[7:6] == 2'b10) begin
                seq_cp   = {seq_cp[14:0], b[5:0]};
                seq_held = seq_held + 3'd1;
                if (seq_held >= seq_len)
                    finish_seq();
            end else begin
                flush_held();
                start_lead(b);
            end
        end else begin
            start_lead(b);
        end
        foreach (item_units[k]) begin
            w.code_unit   = item_units[k];
            w.last_of_run = (k == item_units.size() - 1);
            expected_units = {expected_units, w};
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push      <= 1'b0;
            send_wait <= 0;
        end else begin
            if (push && !full) begin
                decode_item(i_op, i_byte_value);
                items_taken++;
            end
            if (!push || !full) begin
                if (send_wait == 0 && text_items.size() != 0) begin
                    next_item = text_items.pop_front();
                    push         <= 1'b1;
                    i_op         <= next_item.op;
                    i_byte_value <= next_item.b;
                    send_wait    <= $urandom_range(0, gap_max);
                end else begin
                    push <= 1'b0;
                    if (send_wait != 0)
                        send_wait <= send_wait - 1;
                end
            end
        end
    end

    // unit monitor and pop driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop       <= 1'b0;
            recv_wait <= 0;
        end else if (pop && !empty) begin
            if (expected_units.size() == 0) begin
                errors++;
                $display("%0t: unit %h last %0b arrived with nothing expected",
                         $time, o_code_unit, o_last_of_run);
            end else begin
                want = expected_units.pop_front();
                if (o_code_unit !== want.code_unit) begin
                    errors++;
                    $display("%0t: code_unit expected %h actual %h",
                             $time, want.code_unit, o_code_unit);
                end
                if (o_last_of_run !== want.last_of_run) begin
                    errors++;
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, want.last_of_run, o_last_of_run);
                end
            end
            units_checked++;
            if (o_code_unit == u2w_pkg::CP_REPL)
                repl_seen++;
            if (o_code_unit >= u2w_pkg::CP_SURR_LO && o_code_unit <= u2w_pkg::CP_SURR_HI)
                halves_seen++;
            pop_hold = $urandom_range(0, gap_max);
            recv_wait <= pop_hold;
            pop       <= (pop_hold == 0);
        end else if (!pop) begin
            if (recv_wait <= 1)
                pop <= 1'b1;
            if (recv_wait != 0)
                recv_wait <= recv_wait - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL utf8_to_wide_decoder_core");
            $finish;
        end
    end

    task automatic add_item(input logic op, input logic [7:0] b);
        t_text_item t;
        t.op = op;
        t.b  = b;
        text_items = {text_items, t};
    endtask

    function automatic logic [u2w_pkg::CP_W-1:0] pick_code_point(input int len);
        logic bad;
        bad = ($urandom_range(0, 7) == 0);
        case (len)
            1: return u2w_pkg::CP_W'($urandom_range(0, 'h7F));
            2: return bad ? u2w_pkg::CP_W'($urandom_range(0, 'h7F))
                          : u2w_pkg::CP_W'($urandom_range('h80, 'h7FF));
            3: begin
                if (bad)
                    return $urandom_range(0, 1) ? u2w_pkg::CP_W'($urandom_range('hD800, 'hDFFF))
                                                : u2w_pkg::CP_W'($urandom_range(0, 'h7FF));
                return u2w_pkg::CP_W'($urandom_range('h800, 'hFFFF));
            end
            default: begin
                if (bad)
                    return $urandom_range(0, 1)
                        ? u2w_pkg::CP_W'($urandom_range('h110000, 'h1FFFFF))
                        : u2w_pkg::CP_W'($urandom_range(0, 'hFFFF));
                return u2w_pkg::CP_W'($urandom_range('h10000, 'h10FFFF));
            end
        endcase
    endfunction

    // push the first keep bytes of the len-byte encoding of cp
    task automatic add_encoded(input logic [u2w_pkg::CP_W-1:0] cp, input int len,
                               input int keep);
        logic [7:0] enc[4];
        case (len)
            1: enc[0] = cp[7:0];
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            add_item(u2w_pkg::OP_DATA, enc[i]);
    endtask

    // mostly well-formed text, some cut sequences, stray bytes and end marks
    task automatic add_random_text(input int n);
        int added;
        int pick;
        int len;
        int keep;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                len  = $urandom_range(1, 4);
                keep = (pick < 70 || len == 1) ? len : $urandom_range(1, len - 1);
                add_encoded(pick_code_point(len), len, keep);
                added += keep;
            end else begin
                add_item((pick < 92) ? u2w_pkg::OP_DATA : u2w_pkg::OP_EOS,
                         8'($urandom_range(0, 255)));
                added++;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (text_items.size() != 0 || push || expected_units.size() != 0)
            @(negedge i_clk);
        // items that yield no unit may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_mode_readback();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= u2w_pkg::CFG_ADDR_MODE;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {31'd0, mode16}) begin
            errors++;
            $display("%0t: mode readback expected %h actual %h",
                     $time, {31'd0, mode16}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] mode_word, input int gap, input int n);
        cfg_write(u2w_pkg::CFG_ADDR_MODE, mode_word);
        mode16 = mode_word[0];
        check_mode_readback();
        gap_max = gap;
        add_random_text(n);
        wait_idle();
    endtask

    initial begin
        logic [8:0] d;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_mode_readback();
        for (int k = 0; k < DIRECTED_N; k++) begin
            d = DIRECTED[(DIRECTED_N - 1 - k) * 9 +: 9];
            add_item(d[8] ? u2w_pkg::OP_EOS : u2w_pkg::OP_DATA, d[7:0]);
        end
        wait_idle();
        run_phase(32'hFFFF_FFFF, 3, 64);
        run_phase(32'h0000_0000, 0, 64);
        run_phase(32'h0000_0001, 3, 64);
        run_phase(32'hFFFF_FFFE, 3, 64);
        $display("decoded %0d bytes and end marks in both unit modes, with and without idling",
                 items_taken);
        $display("checked %0d units: %0d replacements, %0d surrogate halves",
                 units_checked, repl_seen, halves_seen);
        if (errors == 0) begin
            $display("PASS utf8_to_wide_decoder_core");
        end else begin
            $display("FAIL utf8_to_wide_decoder_core");
        end
        $finish;
    end

endmodule
